// File: rtl/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg
// Widths, pipeline records and per-stage step functions for the circle
// intersection datapath.
// ----------------------------------------------------------------------------
package cci_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
   localparam int EXTRA_BITS   = 7;
   localparam int DELTA_WIDTH  = COORD_WIDTH + 1;
   localparam int DSQ_WIDTH    = 2 * DELTA_WIDTH;
   localparam int RSQ_WIDTH    = 2 * RADIUS_WIDTH;
   localparam int SUMSQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int NUM_WIDTH    = DSQ_WIDTH + 1;
   localparam int NMAG_WIDTH   = SUMSQ_WIDTH + 1;
   localparam int RAD_WIDTH    = SUMSQ_WIDTH + 2 * EXTRA_BITS;
   localparam int ROOT_WIDTH   = RAD_WIDTH / 2;
   localparam int SQREM_WIDTH  = ROOT_WIDTH + 2;
   localparam int QUO_WIDTH    = ROOT_WIDTH;
   localparam int AE_WIDTH     = QUO_WIDTH + 1;
   localparam int PROD_WIDTH   = AE_WIDTH + DELTA_WIDTH;
   localparam int SUMP_WIDTH   = PROD_WIDTH + 1;
   localparam int OFFS_WIDTH   = QUO_WIDTH + 2;
   localparam int STEPS        = ROOT_WIDTH;
   localparam int LANES        = 4;
   localparam int LATENCY      = 13 + 4 * STEPS;

   localparam int LANE_XP = 0;
   localparam int LANE_XM = 1;
   localparam int LANE_YP = 2;
   localparam int LANE_YM = 3;

   typedef struct packed {
      logic [SQREM_WIDTH-1:0] rem;
      logic [ROOT_WIDTH-1:0]  root;
      logic [RAD_WIDTH-1:0]   rad;
   } sq_type;

   typedef struct packed {
      logic [QUO_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0] lo;
      logic [QUO_WIDTH-1:0] quo;
      logic [QUO_WIDTH-1:0] dv;
   } dv_type;

   typedef struct packed {
      logic                          ok;
      logic                          pick;
      logic signed [COORD_WIDTH-1:0] x1;
      logic signed [COORD_WIDTH-1:0] y1;
      logic signed [DELTA_WIDTH-1:0] dx;
      logic signed [DELTA_WIDTH-1:0] dy;
      logic [RSQ_WIDTH-1:0]          r1sq;
      logic                          nneg;
      logic [NMAG_WIDTH-1:0]         nmag;
      logic [ROOT_WIDTH-1:0]         de;
      logic signed [AE_WIDTH-1:0]    ae;
      logic [ROOT_WIDTH-1:0]         he;
   } ctx_type;

   function automatic sq_type sqrt_seed(input logic [RAD_WIDTH-1:0] rad);
      sq_type r;
      r.rem  = '0;
      r.root = '0;
      r.rad  = rad;
      return r;
   endfunction

   function automatic sq_type sqrt_step(input sq_type s);
      logic [SQREM_WIDTH-1:0] rem2;
      logic [SQREM_WIDTH-1:0] trial;
      sq_type r;
      rem2  = {s.rem[SQREM_WIDTH-3:0], s.rad[RAD_WIDTH-1 -: 2]};
      trial = {s.root, 2'b01};
      r.rad = {s.rad[RAD_WIDTH-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = rem2 - trial;
         r.root = {s.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         r.rem  = rem2;
         r.root = {s.root[ROOT_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic dv_type div_seed(input logic [RAD_WIDTH-1:0] dd,
                                       input logic [QUO_WIDTH-1:0] dv);
      dv_type r;
      r.rem = dd[RAD_WIDTH-1:QUO_WIDTH];
      r.lo  = dd[QUO_WIDTH-1:0];
      r.quo = '0;
      r.dv  = dv;
      return r;
   endfunction

   function automatic dv_type div_step(input dv_type s);
      logic [QUO_WIDTH:0] rem2;
      logic [QUO_WIDTH:0] diff;
      dv_type r;
      rem2 = {s.rem, s.lo[QUO_WIDTH-1]};
      diff = rem2 - {1'b0, s.dv};
      r.lo = {s.lo[QUO_WIDTH-2:0], 1'b0};
      r.dv = s.dv;
      if (rem2 >= {1'b0, s.dv}) begin
         r.rem = diff[QUO_WIDTH-1:0];
         r.quo = {s.quo[QUO_WIDTH-2:0], 1'b1};
      end else begin
         r.rem = rem2[QUO_WIDTH-1:0];
         r.quo = {s.quo[QUO_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: rtl/circle_circle_intersection.sv
// ----------------------------------------------------------------------------
// circle_circle_intersection
// Pipelined intersection point of two circles in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the two centres, radii and req_pick_upper with start high; the item
//   is taken at that edge whenever busy is low, and busy stays low, so a new
//   item may enter on every clock.
//   Each result appears on rsp_point_x, rsp_point_y and rsp_found for one
//   cycle with rsp_valid high, and is taken at the edge that ends it.
//   Throughput is one item per cycle. Depth is set by the bit-serial units
//   laid out as stages: two square roots and two rows of dividers, 31
//   stages each, plus 13 stages of squares, products, sums and saturation.
//   rsp_found low means disjoint, nested or concentric circles; the point
//   reads as zero then.
//   Reset clears every valid bit at once; items in flight are dropped and no
//   clearing pass is needed. Results cannot be held off by the receiver, so
//   the pipeline never stalls.
// ----------------------------------------------------------------------------
module circle_circle_intersection (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [cci_pkg::COORD_WIDTH-1:0] req_c1_x,
   input  logic signed [cci_pkg::COORD_WIDTH-1:0] req_c1_y,
   input  logic [cci_pkg::RADIUS_WIDTH-1:0]       req_radius1,
   input  logic signed [cci_pkg::COORD_WIDTH-1:0] req_c2_x,
   input  logic signed [cci_pkg::COORD_WIDTH-1:0] req_c2_y,
   input  logic [cci_pkg::RADIUS_WIDTH-1:0]       req_radius2,
   input  logic                                   req_pick_upper,
   output logic                                   rsp_valid,
   output logic signed [cci_pkg::COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [cci_pkg::COORD_WIDTH-1:0] rsp_point_y,
   output logic                                   rsp_found
);

   logic accept;

   // stage A1
   logic                                   a1_v_ff;
   logic signed [cci_pkg::COORD_WIDTH-1:0] a1_x1_ff, a1_y1_ff;
   logic signed [cci_pkg::DELTA_WIDTH-1:0] a1_dx_ff, a1_dy_ff, a1_dx_in, a1_dy_in;
   logic [cci_pkg::RADIUS_WIDTH-1:0]       a1_r1_ff, a1_r2_ff, a1_diff_ff, a1_diff_in;
   logic [cci_pkg::COORD_WIDTH-1:0]        a1_sum_ff, a1_sum_in;
   logic                                   a1_pick_ff;

   // stage A2
   logic                                   a2_v_ff;
   logic signed [cci_pkg::COORD_WIDTH-1:0] a2_x1_ff, a2_y1_ff;
   logic signed [cci_pkg::DELTA_WIDTH-1:0] a2_dx_ff, a2_dy_ff;
   logic signed [cci_pkg::DSQ_WIDTH-1:0]   a2_dxsq_in, a2_dysq_in;
   logic [cci_pkg::DSQ_WIDTH-1:0]          a2_dxsq_ff, a2_dysq_ff;
   logic [cci_pkg::SUMSQ_WIDTH-1:0]        a2_sumsq_ff;
   logic [cci_pkg::RSQ_WIDTH-1:0]          a2_diffsq_ff, a2_r1sq_ff, a2_r2sq_ff;
   logic                                   a2_pick_ff;

   // stage A3
   logic                                   a3_v_ff;
   logic signed [cci_pkg::COORD_WIDTH-1:0] a3_x1_ff, a3_y1_ff;
   logic signed [cci_pkg::DELTA_WIDTH-1:0] a3_dx_ff, a3_dy_ff;
   logic [cci_pkg::DSQ_WIDTH-1:0]          a3_d2_ff, a3_d2_in;
   logic [cci_pkg::NUM_WIDTH-1:0]          a3_num_ff, a3_num_in;
   logic [cci_pkg::SUMSQ_WIDTH-1:0]        a3_sumsq_ff;
   logic [cci_pkg::RSQ_WIDTH-1:0]          a3_diffsq_ff, a3_r1sq_ff;
   logic                                   a3_pick_ff;

   // stage A4
   logic                           a4_v_ff;
   cci_pkg::ctx_type               a4_ctx_ff, a4_ctx_in;
   logic [cci_pkg::RAD_WIDTH-1:0]  a4_rad_ff, a4_rad_in;
   logic [cci_pkg::NUM_WIDTH-1:0]  a4_nabs;

   // distance root
   cci_pkg::sq_type  sq1_ff [cci_pkg::STEPS];
   cci_pkg::sq_type  sq1_in [cci_pkg::STEPS];
   cci_pkg::ctx_type sq1_ctx_ff [cci_pkg::STEPS];
   logic             sq1_v_ff [cci_pkg::STEPS];

   // a = N / (2d)
   cci_pkg::dv_type  dv1_ff [cci_pkg::STEPS];
   cci_pkg::dv_type  dv1_in [cci_pkg::STEPS];
   cci_pkg::ctx_type dv1_ctx_ff [cci_pkg::STEPS];
   cci_pkg::ctx_type dv1_ctx_seed;
   logic             dv1_v_ff [cci_pkg::STEPS];

   // stage B1, B2
   logic                          b1_v_ff;
   cci_pkg::ctx_type              b1_ctx_ff, b1_ctx_in;
   logic [cci_pkg::RAD_WIDTH-1:0] b1_qsq_ff, b1_qsq_in;
   logic [cci_pkg::QUO_WIDTH-1:0] b1_q;
   logic                          b2_v_ff;
   cci_pkg::ctx_type              b2_ctx_ff;
   logic [cci_pkg::RAD_WIDTH:0]   b2_hh;
   logic [cci_pkg::RAD_WIDTH-1:0] b2_rad_ff, b2_rad_in;

   // h root
   cci_pkg::sq_type  sq2_ff [cci_pkg::STEPS];
   cci_pkg::sq_type  sq2_in [cci_pkg::STEPS];
   cci_pkg::ctx_type sq2_ctx_ff [cci_pkg::STEPS];
   logic             sq2_v_ff [cci_pkg::STEPS];

   // stages C1..C4
   logic                                  c1_v_ff, c2_v_ff, c3_v_ff, c4_v_ff;
   cci_pkg::ctx_type                      c1_ctx_ff, c1_ctx_in, c2_ctx_ff, c3_ctx_ff;
   cci_pkg::ctx_type                      c4_ctx_ff;
   logic signed [cci_pkg::AE_WIDTH-1:0]   c1_hes;
   logic signed [cci_pkg::PROD_WIDTH-1:0] c1_p_ff [cci_pkg::LANES];
   logic signed [cci_pkg::PROD_WIDTH-1:0] c1_p_in [cci_pkg::LANES];
   logic signed [cci_pkg::SUMP_WIDTH-1:0] c2_n_ff [cci_pkg::LANES];
   logic signed [cci_pkg::SUMP_WIDTH-1:0] c2_n_in [cci_pkg::LANES];
   logic [cci_pkg::SUMP_WIDTH-1:0]        c3_mag_ff [cci_pkg::LANES];
   logic [cci_pkg::SUMP_WIDTH-1:0]        c3_mag_in [cci_pkg::LANES];
   logic [cci_pkg::LANES-1:0]             c3_neg_ff, c4_neg_ff;
   logic [cci_pkg::RAD_WIDTH-1:0]         c4_m_ff [cci_pkg::LANES];
   logic [cci_pkg::RAD_WIDTH-1:0]         c4_m_in [cci_pkg::LANES];

   // rounded offsets
   cci_pkg::dv_type           dv2_ff [cci_pkg::LANES][cci_pkg::STEPS];
   cci_pkg::dv_type           dv2_in [cci_pkg::LANES][cci_pkg::STEPS];
   logic [cci_pkg::LANES-1:0] dv2_neg_ff [cci_pkg::STEPS];
   cci_pkg::ctx_type          dv2_ctx_ff [cci_pkg::STEPS];
   logic                      dv2_v_ff [cci_pkg::STEPS];

   // stages D1..D3
   logic                                   d1_v_ff, d2_v_ff;
   logic                                   d1_ok_ff, d1_pick_ff, d2_ok_ff, d2_pick_ff;
   logic signed [cci_pkg::OFFS_WIDTH-1:0]  d1_s_ff [cci_pkg::LANES];
   logic signed [cci_pkg::OFFS_WIDTH-1:0]  d1_s_in [cci_pkg::LANES];
   logic signed [cci_pkg::COORD_WIDTH-1:0] d2_c_ff [cci_pkg::LANES];
   logic signed [cci_pkg::COORD_WIDTH-1:0] d2_c_in [cci_pkg::LANES];
   logic                                   d3_minus;
   logic                                   rsp_valid_ff, rsp_found_ff, rsp_found_in;
   logic signed [cci_pkg::COORD_WIDTH-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---------------- A stages: deltas, squares, sums, range test -----------
   assign a1_dx_in   = {req_c2_x[cci_pkg::COORD_WIDTH-1], req_c2_x}
                     - {req_c1_x[cci_pkg::COORD_WIDTH-1], req_c1_x};
   assign a1_dy_in   = {req_c2_y[cci_pkg::COORD_WIDTH-1], req_c2_y}
                     - {req_c1_y[cci_pkg::COORD_WIDTH-1], req_c1_y};
   assign a1_sum_in  = {1'b0, req_radius1} + {1'b0, req_radius2};
   assign a1_diff_in = (req_radius1 > req_radius2) ? req_radius1 - req_radius2
                                                   : req_radius2 - req_radius1;

   assign a2_dxsq_in = a1_dx_ff * a1_dx_ff;
   assign a2_dysq_in = a1_dy_ff * a1_dy_ff;

   assign a3_d2_in  = a2_dxsq_ff + a2_dysq_ff;
   assign a3_num_in = cci_pkg::NUM_WIDTH'(a2_r1sq_ff) - cci_pkg::NUM_WIDTH'(a2_r2sq_ff)
                    + cci_pkg::NUM_WIDTH'(a2_dxsq_ff) + cci_pkg::NUM_WIDTH'(a2_dysq_ff);

   assign a4_nabs   = a3_num_ff[cci_pkg::NUM_WIDTH-1] ? -a3_num_ff : a3_num_ff;
   assign a4_rad_in = {a3_d2_ff[cci_pkg::SUMSQ_WIDTH-1:0], {(2*cci_pkg::EXTRA_BITS){1'b0}}};

   always_comb begin
      a4_ctx_in      = '0;
      a4_ctx_in.ok   = (a3_d2_ff != '0)
                    && (a3_d2_ff <= cci_pkg::DSQ_WIDTH'(a3_sumsq_ff))
                    && (a3_d2_ff >= cci_pkg::DSQ_WIDTH'(a3_diffsq_ff));
      a4_ctx_in.pick = a3_pick_ff;
      a4_ctx_in.x1   = a3_x1_ff;
      a4_ctx_in.y1   = a3_y1_ff;
      a4_ctx_in.dx   = a3_dx_ff;
      a4_ctx_in.dy   = a3_dy_ff;
      a4_ctx_in.r1sq = a3_r1sq_ff;
      a4_ctx_in.nneg = a3_num_ff[cci_pkg::NUM_WIDTH-1];
      a4_ctx_in.nmag = a4_nabs[cci_pkg::NMAG_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      a1_x1_ff     <= req_c1_x;
      a1_y1_ff     <= req_c1_y;
      a1_dx_ff     <= a1_dx_in;
      a1_dy_ff     <= a1_dy_in;
      a1_r1_ff     <= req_radius1;
      a1_r2_ff     <= req_radius2;
      a1_sum_ff    <= a1_sum_in;
      a1_diff_ff   <= a1_diff_in;
      a1_pick_ff   <= req_pick_upper;

      a2_x1_ff     <= a1_x1_ff;
      a2_y1_ff     <= a1_y1_ff;
      a2_dx_ff     <= a1_dx_ff;
      a2_dy_ff     <= a1_dy_ff;
      a2_dxsq_ff   <= $unsigned(a2_dxsq_in);
      a2_dysq_ff   <= $unsigned(a2_dysq_in);
      a2_sumsq_ff  <= a1_sum_ff * a1_sum_ff;
      a2_diffsq_ff <= a1_diff_ff * a1_diff_ff;
      a2_r1sq_ff   <= a1_r1_ff * a1_r1_ff;
      a2_r2sq_ff   <= a1_r2_ff * a1_r2_ff;
      a2_pick_ff   <= a1_pick_ff;

      a3_x1_ff     <= a2_x1_ff;
      a3_y1_ff     <= a2_y1_ff;
      a3_dx_ff     <= a2_dx_ff;
      a3_dy_ff     <= a2_dy_ff;
      a3_d2_ff     <= a3_d2_in;
      a3_num_ff    <= a3_num_in;
      a3_sumsq_ff  <= a2_sumsq_ff;
      a3_diffsq_ff <= a2_diffsq_ff;
      a3_r1sq_ff   <= a2_r1sq_ff;
      a3_pick_ff   <= a2_pick_ff;

      a4_ctx_ff    <= a4_ctx_in;
      a4_rad_ff    <= a4_rad_in;
   end

   // ---------------- distance root, one result bit per stage ---------------
   always_comb begin
      sq1_in[0] = cci_pkg::sqrt_step(cci_pkg::sqrt_seed(a4_rad_ff));
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         sq1_in[i] = cci_pkg::sqrt_step(sq1_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      sq1_ctx_ff[0] <= a4_ctx_ff;
      for (int i = 0; i < cci_pkg::STEPS; i++) begin
         sq1_ff[i] <= sq1_in[i];
      end
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         sq1_ctx_ff[i] <= sq1_ctx_ff[i-1];
      end
   end

   // ---------------- a with extra bits, one quotient bit per stage ---------
   always_comb begin
      dv1_ctx_seed    = sq1_ctx_ff[cci_pkg::STEPS-1];
      dv1_ctx_seed.de = sq1_ff[cci_pkg::STEPS-1].root;
      dv1_in[0] = cci_pkg::div_step(cci_pkg::div_seed(
                     {dv1_ctx_seed.nmag, {(2*cci_pkg::EXTRA_BITS-1){1'b0}}},
                     dv1_ctx_seed.de));
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         dv1_in[i] = cci_pkg::div_step(dv1_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      dv1_ctx_ff[0] <= dv1_ctx_seed;
      for (int i = 0; i < cci_pkg::STEPS; i++) begin
         dv1_ff[i] <= dv1_in[i];
      end
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         dv1_ctx_ff[i] <= dv1_ctx_ff[i-1];
      end
   end

   // ---------------- B stages: r1^2 - a^2, clamp at zero ------------------
   assign b1_q      = dv1_ff[cci_pkg::STEPS-1].quo;
   assign b1_qsq_in = b1_q * b1_q;

   always_comb begin
      b1_ctx_in    = dv1_ctx_ff[cci_pkg::STEPS-1];
      b1_ctx_in.ae = b1_ctx_in.nneg ? -$signed(cci_pkg::AE_WIDTH'(b1_q))
                                    : $signed(cci_pkg::AE_WIDTH'(b1_q));
   end

   assign b2_hh     = (cci_pkg::RAD_WIDTH+1)'({b1_ctx_ff.r1sq, {(2*cci_pkg::EXTRA_BITS){1'b0}}})
                    - (cci_pkg::RAD_WIDTH+1)'(b1_qsq_ff);
   assign b2_rad_in = b2_hh[cci_pkg::RAD_WIDTH] ? '0 : b2_hh[cci_pkg::RAD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      b1_ctx_ff <= b1_ctx_in;
      b1_qsq_ff <= b1_qsq_in;
      b2_ctx_ff <= b1_ctx_ff;
      b2_rad_ff <= b2_rad_in;
   end

   // ---------------- h root ------------------------------------------------
   always_comb begin
      sq2_in[0] = cci_pkg::sqrt_step(cci_pkg::sqrt_seed(b2_rad_ff));
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         sq2_in[i] = cci_pkg::sqrt_step(sq2_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      sq2_ctx_ff[0] <= b2_ctx_ff;
      for (int i = 0; i < cci_pkg::STEPS; i++) begin
         sq2_ff[i] <= sq2_in[i];
      end
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         sq2_ctx_ff[i] <= sq2_ctx_ff[i-1];
      end
   end

   // ---------------- C stages: products, sums, magnitude, round bias -------
   always_comb begin
      c1_ctx_in    = sq2_ctx_ff[cci_pkg::STEPS-1];
      c1_ctx_in.he = sq2_ff[cci_pkg::STEPS-1].root;
   end

   assign c1_hes = $signed({1'b0, c1_ctx_in.he});
   assign c1_p_in[cci_pkg::LANE_XP] = c1_ctx_in.ae * c1_ctx_in.dx;
   assign c1_p_in[cci_pkg::LANE_XM] = c1_hes * c1_ctx_in.dy;
   assign c1_p_in[cci_pkg::LANE_YP] = c1_ctx_in.ae * c1_ctx_in.dy;
   assign c1_p_in[cci_pkg::LANE_YM] = c1_hes * c1_ctx_in.dx;

   assign c2_n_in[cci_pkg::LANE_XP] = cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_XP])
                                    - cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_XM]);
   assign c2_n_in[cci_pkg::LANE_XM] = cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_XP])
                                    + cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_XM]);
   assign c2_n_in[cci_pkg::LANE_YP] = cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_YP])
                                    + cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_YM]);
   assign c2_n_in[cci_pkg::LANE_YM] = cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_YP])
                                    - cci_pkg::SUMP_WIDTH'(c1_p_ff[cci_pkg::LANE_YM]);

   always_comb begin
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         c3_mag_in[k] = c2_n_ff[k][cci_pkg::SUMP_WIDTH-1] ? $unsigned(-c2_n_ff[k])
                                                          : $unsigned(c2_n_ff[k]);
         c4_m_in[k]   = cci_pkg::RAD_WIDTH'(c3_mag_ff[k])
                      + cci_pkg::RAD_WIDTH'(c3_ctx_ff.de >> 1);
      end
   end

   always_ff @(posedge clock) begin
      c1_ctx_ff <= c1_ctx_in;
      c2_ctx_ff <= c1_ctx_ff;
      c3_ctx_ff <= c2_ctx_ff;
      c4_ctx_ff <= c3_ctx_ff;
      c4_neg_ff <= c3_neg_ff;
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         c1_p_ff[k]   <= c1_p_in[k];
         c2_n_ff[k]   <= c2_n_in[k];
         c3_mag_ff[k] <= c3_mag_in[k];
         c3_neg_ff[k] <= c2_n_ff[k][cci_pkg::SUMP_WIDTH-1];
         c4_m_ff[k]   <= c4_m_in[k];
      end
   end

   // ---------------- offsets divided by d, four lanes ----------------------
   always_comb begin
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         dv2_in[k][0] = cci_pkg::div_step(cci_pkg::div_seed(c4_m_ff[k], c4_ctx_ff.de));
         for (int i = 1; i < cci_pkg::STEPS; i++) begin
            dv2_in[k][i] = cci_pkg::div_step(dv2_ff[k][i-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      dv2_ctx_ff[0] <= c4_ctx_ff;
      dv2_neg_ff[0] <= c4_neg_ff;
      for (int i = 1; i < cci_pkg::STEPS; i++) begin
         dv2_ctx_ff[i] <= dv2_ctx_ff[i-1];
         dv2_neg_ff[i] <= dv2_neg_ff[i-1];
      end
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         for (int i = 0; i < cci_pkg::STEPS; i++) begin
            dv2_ff[k][i] <= dv2_in[k][i];
         end
      end
   end

   // ---------------- D stages: add to c1, saturate, pick -------------------
   always_comb begin
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         if (dv2_neg_ff[cci_pkg::STEPS-1][k]) begin
            d1_s_in[k] = ((k < cci_pkg::LANE_YP) ?
                            cci_pkg::OFFS_WIDTH'(dv2_ctx_ff[cci_pkg::STEPS-1].x1) :
                            cci_pkg::OFFS_WIDTH'(dv2_ctx_ff[cci_pkg::STEPS-1].y1))
                       - $signed(cci_pkg::OFFS_WIDTH'(dv2_ff[k][cci_pkg::STEPS-1].quo));
         end else begin
            d1_s_in[k] = ((k < cci_pkg::LANE_YP) ?
                            cci_pkg::OFFS_WIDTH'(dv2_ctx_ff[cci_pkg::STEPS-1].x1) :
                            cci_pkg::OFFS_WIDTH'(dv2_ctx_ff[cci_pkg::STEPS-1].y1))
                       + $signed(cci_pkg::OFFS_WIDTH'(dv2_ff[k][cci_pkg::STEPS-1].quo));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         priority if ((d1_s_ff[k][cci_pkg::OFFS_WIDTH-1:cci_pkg::COORD_WIDTH-1] == '0)
                   || (d1_s_ff[k][cci_pkg::OFFS_WIDTH-1:cci_pkg::COORD_WIDTH-1] == '1)) begin
            d2_c_in[k] = d1_s_ff[k][cci_pkg::COORD_WIDTH-1:0];
         end else if (d1_s_ff[k][cci_pkg::OFFS_WIDTH-1]) begin
            d2_c_in[k] = {1'b1, {(cci_pkg::COORD_WIDTH-1){1'b0}}};
         end else begin
            d2_c_in[k] = {1'b0, {(cci_pkg::COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   assign d3_minus     = d2_pick_ff ? (d2_c_ff[cci_pkg::LANE_YM] > d2_c_ff[cci_pkg::LANE_YP])
                                    : (d2_c_ff[cci_pkg::LANE_YM] < d2_c_ff[cci_pkg::LANE_YP]);
   assign rsp_found_in = d2_ok_ff;
   assign rsp_x_in     = !d2_ok_ff ? '0 :
                         d3_minus ? d2_c_ff[cci_pkg::LANE_XM] : d2_c_ff[cci_pkg::LANE_XP];
   assign rsp_y_in     = !d2_ok_ff ? '0 :
                         d3_minus ? d2_c_ff[cci_pkg::LANE_YM] : d2_c_ff[cci_pkg::LANE_YP];

   always_ff @(posedge clock) begin
      d1_ok_ff     <= dv2_ctx_ff[cci_pkg::STEPS-1].ok;
      d1_pick_ff   <= dv2_ctx_ff[cci_pkg::STEPS-1].pick;
      d2_ok_ff     <= d1_ok_ff;
      d2_pick_ff   <= d1_pick_ff;
      for (int k = 0; k < cci_pkg::LANES; k++) begin
         d1_s_ff[k] <= d1_s_in[k];
         d2_c_ff[k] <= d2_c_in[k];
      end
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   // ---------------- valid bits --------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff      <= 1'b0;
         a2_v_ff      <= 1'b0;
         a3_v_ff      <= 1'b0;
         a4_v_ff      <= 1'b0;
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         c1_v_ff      <= 1'b0;
         c2_v_ff      <= 1'b0;
         c3_v_ff      <= 1'b0;
         c4_v_ff      <= 1'b0;
         d1_v_ff      <= 1'b0;
         d2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < cci_pkg::STEPS; i++) begin
            sq1_v_ff[i] <= 1'b0;
            dv1_v_ff[i] <= 1'b0;
            sq2_v_ff[i] <= 1'b0;
            dv2_v_ff[i] <= 1'b0;
         end
      end else begin
         a1_v_ff      <= accept;
         a2_v_ff      <= a1_v_ff;
         a3_v_ff      <= a2_v_ff;
         a4_v_ff      <= a3_v_ff;
         sq1_v_ff[0]  <= a4_v_ff;
         dv1_v_ff[0]  <= sq1_v_ff[cci_pkg::STEPS-1];
         b1_v_ff      <= dv1_v_ff[cci_pkg::STEPS-1];
         b2_v_ff      <= b1_v_ff;
         sq2_v_ff[0]  <= b2_v_ff;
         c1_v_ff      <= sq2_v_ff[cci_pkg::STEPS-1];
         c2_v_ff      <= c1_v_ff;
         c3_v_ff      <= c2_v_ff;
         c4_v_ff      <= c3_v_ff;
         dv2_v_ff[0]  <= c4_v_ff;
         d1_v_ff      <= dv2_v_ff[cci_pkg::STEPS-1];
         d2_v_ff      <= d1_v_ff;
         rsp_valid_ff <= d2_v_ff;
         for (int i = 1; i < cci_pkg::STEPS; i++) begin
            sq1_v_ff[i] <= sq1_v_ff[i-1];
            dv1_v_ff[i] <= dv1_v_ff[i-1];
            sq2_v_ff[i] <= sq2_v_ff[i-1];
            dv2_v_ff[i] <= dv2_v_ff[i-1];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, cci_pkg::LATENCY))
      else $error("result strobe without an item accepted at the pipeline depth");

   a_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_point_x == '0 && rsp_point_y == '0)
      else $error("point not cleared for a pair without intersection");

   a_distance: assert property (@(posedge clock) disable iff (reset)
      sq1_v_ff[cci_pkg::STEPS-1] && sq1_ctx_ff[cci_pkg::STEPS-1].ok
      |-> sq1_ff[cci_pkg::STEPS-1].root[cci_pkg::ROOT_WIDTH-1:cci_pkg::EXTRA_BITS] != '0)
      else $error("distance below one LSB for an intersecting pair");
`endif

endmodule

// File: tb/sv/circle_circle_intersection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_circle_intersection_tb
// Drives circle pairs into the intersection pipeline, first from a directed
// table (no-hit cases, touching circles, coordinate extremes, saturation),
// then mostly intersecting random pairs mixed with raw random fields.
// Every result is checked field by field against a local fixed-point
// predictor.
// ----------------------------------------------------------------------------
module circle_circle_intersection_tb;

   localparam longint CMAX = (64'sd1 <<< (cci_pkg::COORD_WIDTH - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;
   localparam longint RMAX = (64'sd1 <<< cci_pkg::RADIUS_WIDTH) - 1;
   localparam int EXT = 7;
   localparam int RANDOM_ITEMS = 850;
   localparam int IDLE_LIMIT = 4000;

   typedef logic signed [cci_pkg::COORD_WIDTH-1:0] coord_type;
   typedef logic [cci_pkg::RADIUS_WIDTH-1:0]       radius_type;

   typedef struct {
      coord_type  c1_x, c1_y, c2_x, c2_y;
      radius_type r1, r2;
      logic       upper;
   } circles_type;

   typedef struct {
      coord_type x, y;
      logic      found;
   } point_type;

   typedef struct {
      circles_type c;
      logic        typed;
      point_type   pt;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   coord_type  req_c1_x = 0, req_c1_y = 0, req_c2_x = 0, req_c2_y = 0;
   radius_type req_radius1 = 0, req_radius2 = 0;
   logic req_pick_upper = 0;
   logic rsp_valid, rsp_found;
   coord_type rsp_point_x, rsp_point_y;

   point_type expected_points[$];
   row_type   directed_rows[$];
   int        mismatches = 0;
   int        idle_cycles = 0;

   circle_circle_intersection u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_c1_x(req_c1_x), .req_c1_y(req_c1_y), .req_radius1(req_radius1),
      .req_c2_x(req_c2_x), .req_c2_y(req_c2_y), .req_radius2(req_radius2),
      .req_pick_upper(req_pick_upper), .rsp_valid(rsp_valid),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_found(rsp_found)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_div(input longint n, input longint dv);
      longint unsigned m, q;
      m = (n < 0) ? -n : n;
      q = (m + dv / 2) / dv;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_coord(input longint v);
      return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
   endfunction

   function automatic point_type predict_intersection(input circles_type c);
      longint x1, y1, r1, r2, dx, dy, de, n, ae, r1e, hh, he;
      longint pxp, pyp, pxm, pym;
      longint unsigned d2, sm, df;
      point_type p;
      x1 = c.c1_x;
      y1 = c.c1_y;
      r1 = c.r1;
      r2 = c.r2;
      dx = longint'(c.c2_x) - x1;
      dy = longint'(c.c2_y) - y1;
      d2 = dx * dx + dy * dy;
      sm = r1 + r2;
      df = (r1 > r2) ? r1 - r2 : r2 - r1;
      p.x = 0;
      p.y = 0;
      p.found = 0;
      if (d2 == 0 || d2 > sm * sm || d2 < df * df) return p;
      de = int_sqrt(d2 << (2 * EXT));
      n = r1 * r1 - r2 * r2 + longint'(d2);
      ae = (n * (64'sd1 <<< (2 * EXT - 1))) / de;
      r1e = r1 * (64'sd1 <<< EXT);
      hh = r1e * r1e - ae * ae;
      he = (hh > 0) ? longint'(int_sqrt(hh)) : 0;
      pxp = clamp_coord(x1 + round_div(ae * dx - he * dy, de));
      pyp = clamp_coord(y1 + round_div(ae * dy + he * dx, de));
      pxm = clamp_coord(x1 + round_div(ae * dx + he * dy, de));
      pym = clamp_coord(y1 + round_div(ae * dy - he * dx, de));
      p.x = coord_type'(pxp);
      p.y = coord_type'(pyp);
      if (c.upper ? (pym > pyp) : (pym < pyp)) begin
         p.x = coord_type'(pxm);
         p.y = coord_type'(pym);
      end
      p.found = 1;
      return p;
   endfunction

   function automatic circles_type make_circles(input longint x1, y1, r1, x2, y2, r2,
                                                input bit up);
      circles_type c;
      c.c1_x = coord_type'(x1); c.c1_y = coord_type'(y1); c.r1 = radius_type'(r1);
      c.c2_x = coord_type'(x2); c.c2_y = coord_type'(y2); c.r2 = radius_type'(r2);
      c.upper = up;
      return c;
   endfunction

   task automatic add_row(input circles_type c, input bit typed,
                          input longint px = 0, input longint py = 0, input bit f = 0);
      row_type r;
      r.c = c;
      r.typed = typed;
      r.pt.x = coord_type'(px);
      r.pt.y = coord_type'(py);
      r.pt.found = f;
      directed_rows.push_back(r);
   endtask

   function automatic circles_type random_circles();
      circles_type c;
      longint x1, y1, x2, y2, d, r1, r2, lo, hi, s;
      if ($urandom_range(0, 4) == 0) begin
         c.c1_x = coord_type'($urandom); c.c1_y = coord_type'($urandom);
         c.r1 = radius_type'($urandom);
         c.c2_x = coord_type'($urandom); c.c2_y = coord_type'($urandom);
         c.r2 = radius_type'($urandom);
         c.upper = 1'($urandom);
         return c;
      end
      s = 64'sd1 <<< $urandom_range(1, 23);
      x1 = longint'(coord_type'($urandom));
      y1 = longint'(coord_type'($urandom));
      x2 = clamp_coord(x1 + longint'($urandom_range(0, 2 * s)) - s);
      y2 = clamp_coord(y1 + longint'($urandom_range(0, 2 * s)) - s);
      d = int_sqrt((x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1));
      hi = (2 * d > RMAX) ? RMAX : 2 * d;
      r1 = $urandom_range(0, hi);
      lo = (d > r1) ? d - r1 : r1 - d;
      hi = (d + r1 > RMAX) ? RMAX : d + r1;
      r2 = (lo > RMAX) ? RMAX : longint'($urandom_range(lo, hi));
      return make_circles(x1, y1, r1, x2, y2, r2, 1'($urandom));
   endfunction

   task automatic send_item(input circles_type c);
      start <= 1;
      req_c1_x <= c.c1_x; req_c1_y <= c.c1_y; req_radius1 <= c.r1;
      req_c2_x <= c.c2_x; req_c2_y <= c.c2_y; req_radius2 <= c.r2;
      req_pick_upper <= c.upper;
      do @(posedge clock); while (busy);
      if ($urandom_range(0, 2) == 0) begin
         start <= 0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      point_type e;
      if (!reset && start && !busy)
         expected_points.push_back(predict_intersection(make_circles(
            req_c1_x, req_c1_y, req_radius1, req_c2_x, req_c2_y, req_radius2,
            req_pick_upper)));
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d y=%0d found=%0b",
                                           rsp_point_x, rsp_point_y, rsp_found);
         end else begin
            e = expected_points.pop_front();
            if (e.x !== rsp_point_x || e.y !== rsp_point_y || e.found !== rsp_found) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                           e.x, e.y, e.found, rsp_point_x, rsp_point_y, rsp_found);
            end
         end
      end
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      row_type   r;
      point_type p;
      // coincident centres, disjoint, nested
      add_row(make_circles(100, 100, 50, 100, 100, 50, 0), 1);
      add_row(make_circles(0, 0, 256, 1000, 0, 256, 1), 1);
      add_row(make_circles(0, 0, 2000, 10, 0, 100, 0), 1);
      add_row(make_circles(0, 0, 0, 0, 0, 0, 1), 1);
      // touching from outside, from inside
      add_row(make_circles(0, 0, 256, 512, 0, 256, 0), 1, 256, 0, 1);
      add_row(make_circles(0, 0, 512, 256, 0, 256, 1), 1, 512, 0, 1);
      // both selections, ties in y
      add_row(make_circles(0, 0, 500, 0, 600, 500, 0), 0);
      add_row(make_circles(0, 0, 500, 0, 600, 500, 1), 0);
      add_row(make_circles(0, 0, 500, 600, 0, 500, 0), 0);
      add_row(make_circles(0, 0, 500, 600, 0, 500, 1), 0);
      // extreme coordinates and radii, saturation
      add_row(make_circles(CMIN, CMIN, RMAX, CMAX, CMAX, RMAX, 0), 1);
      add_row(make_circles(CMIN, CMIN, RMAX, CMIN, CMAX, RMAX, 1), 0);
      add_row(make_circles(CMAX, CMAX, RMAX, CMAX, CMIN, RMAX, 0), 0);
      add_row(make_circles(CMAX, 0, 4000000, CMAX, 100, 4000000, 1), 0);
      add_row(make_circles(CMIN, 0, 4000000, CMIN, 100, 4000000, 0), 0);
      add_row(make_circles(0, CMAX, 4000000, 100, CMAX, 4000000, 1), 0);
      add_row(make_circles(0, CMIN, 4000000, 100, CMIN, 4000000, 0), 0);
      add_row(make_circles(CMAX, CMAX, RMAX, CMAX - 1, CMAX, RMAX, 1), 0);
      add_row(make_circles(-1, -1, 1, 0, -1, 1, 0), 0);

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.typed) begin
            p = predict_intersection(r.c);
            if (p.x !== r.pt.x || p.y !== r.pt.y || p.found !== r.pt.found) begin
               mismatches++;
               if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
            end
         end
         send_item(r.c);
      end
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_item(random_circles());
         if (i == RANDOM_ITEMS / 2) drain();
      end

      drain();
      repeat (cci_pkg::LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
